### sv/s20c_pkg.sv
// Shared types, constants and quarter-round tables for the Salsa20 core block.
package s20c_pkg;

  localparam int MAX_ROUNDS   = 20;
  localparam int MAX_DOUBLES  = (MAX_ROUNDS + 1) / 2;
  localparam int STEPS_PER_DR = 8;
  localparam int NUM_CELLS    = MAX_DOUBLES * STEPS_PER_DR;
  localparam int DR_W         = $clog2(MAX_DOUBLES + 1);
  localparam int RC_W         = 5;

  localparam logic [RC_W-1:0] RC_RESET = RC_W'(20);
  localparam logic [RC_W:0]   RC_MAX   = (RC_W+1)'(MAX_ROUNDS);

  // Operation within one quarter-round, in order of execution.
  localparam logic [1:0] QR_OP_B = 2'd0;
  localparam logic [1:0] QR_OP_C = 2'd1;
  localparam logic [1:0] QR_OP_D = 2'd2;
  localparam logic [1:0] QR_OP_A = 2'd3;

  typedef logic [15:0][31:0] word_arr_t;

  typedef struct packed {
    logic [63:0] in_words_14_15;
    logic [63:0] in_words_12_13;
    logic [63:0] in_words_10_11;
    logic [63:0] in_words_8_9;
    logic [63:0] in_words_6_7;
    logic [63:0] in_words_4_5;
    logic [63:0] in_words_2_3;
    logic [63:0] in_words_0_1;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_words_14_15;
    logic [63:0] out_words_12_13;
    logic [63:0] out_words_10_11;
    logic [63:0] out_words_8_9;
    logic [63:0] out_words_6_7;
    logic [63:0] out_words_4_5;
    logic [63:0] out_words_2_3;
    logic [63:0] out_words_0_1;
  } out_item_t;

  // One transaction as it travels down the chain.
  typedef struct packed {
    logic            valid;
    logic [DR_W-1:0] doubles;
    word_arr_t       orig;
    word_arr_t       work;
  } stage_t;

  // Word indexes {a, b, c, d} of quarter-round lane for column (half 0) or row (half 1).
  function automatic logic [15:0] qr_words(input logic half, input logic [1:0] lane);
    logic [15:0] q;
    unique case ({half, lane})
      3'd0:    q = {4'd0,  4'd4,  4'd8,  4'd12};
      3'd1:    q = {4'd5,  4'd9,  4'd13, 4'd1};
      3'd2:    q = {4'd10, 4'd14, 4'd2,  4'd6};
      3'd3:    q = {4'd15, 4'd3,  4'd7,  4'd11};
      3'd4:    q = {4'd0,  4'd1,  4'd2,  4'd3};
      3'd5:    q = {4'd5,  4'd6,  4'd7,  4'd4};
      3'd6:    q = {4'd10, 4'd11, 4'd8,  4'd9};
      default: q = {4'd15, 4'd12, 4'd13, 4'd14};
    endcase
    return q;
  endfunction

  // Left rotation by 7, 9, 13 or 18 depending on the operation.
  function automatic logic [31:0] qr_rot(input logic [31:0] v, input logic [1:0] op);
    logic [31:0] r;
    unique case (op)
      QR_OP_B: r = {v[24:0], v[31:25]};
      QR_OP_C: r = {v[22:0], v[31:23]};
      QR_OP_D: r = {v[18:0], v[31:19]};
      default: r = {v[13:0], v[31:14]};
    endcase
    return r;
  endfunction

endpackage

### sv/s20c_cell.sv
// One chain cell: the same add-rotate-xor operation on all four quarter-round lanes.
module s20c_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [2:0]                cell_step,
  input  logic [s20c_pkg::DR_W-1:0] cell_round,
  input  s20c_pkg::stage_t          stage_in,
  output s20c_pkg::stage_t          stage_out
);
  import s20c_pkg::*;

  logic            valid_r;
  logic [DR_W-1:0] doubles_r;
  word_arr_t       orig_r;
  word_arr_t       work_r;
  word_arr_t       work_nxt;
  word_arr_t       step_res;
  logic [15:0]     qd   [4];
  logic [3:0]      tgt  [4];
  logic [3:0]      src1 [4];
  logic [3:0]      src2 [4];
  logic [31:0]     sum  [4];

  always_comb begin
    step_res = stage_in.work;
    for (int l = 0; l < 4; l++) begin
      qd[l] = qr_words(cell_step[2], 2'(l));
      unique case (cell_step[1:0])
        QR_OP_B: begin
          tgt[l] = qd[l][11:8]; src1[l] = qd[l][15:12]; src2[l] = qd[l][3:0];
        end
        QR_OP_C: begin
          tgt[l] = qd[l][7:4];  src1[l] = qd[l][11:8];  src2[l] = qd[l][15:12];
        end
        QR_OP_D: begin
          tgt[l] = qd[l][3:0];  src1[l] = qd[l][7:4];   src2[l] = qd[l][11:8];
        end
        default: begin
          tgt[l] = qd[l][15:12]; src1[l] = qd[l][3:0];  src2[l] = qd[l][7:4];
        end
      endcase
      sum[l] = stage_in.work[src1[l]] + stage_in.work[src2[l]];
      step_res[tgt[l]] = stage_in.work[tgt[l]] ^ qr_rot(sum[l], cell_step[1:0]);
    end
    // Pass the words through once this block's double rounds are done.
    work_nxt = (cell_round < stage_in.doubles) ? step_res : stage_in.work;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      doubles_r <= stage_in.doubles;
      orig_r    <= stage_in.orig;
      work_r    <= work_nxt;
    end
  end

  assign stage_out = '{valid: valid_r, doubles: doubles_r, orig: orig_r, work: work_r};

endmodule

### sv/salsa20_core_block.sv
// Salsa20 core hash block top level: chain of round cells and the output register.
// Salsa20 core hash. Each transaction carries one 64-byte block as sixteen 32-bit
// words and yields the sixteen result words after ceil(round_count/2) double rounds
// and the final feed-forward add. The block is a chain of 80 cells, eight per double
// round, each doing one add-rotate-xor on the four independent quarter-round lanes,
// followed by an output register that adds the input words back. A new block is
// accepted every cycle while in_stall is low; each block passes through all 80 cells
// and the output register whatever the round count, since cells beyond the configured
// count pass data on. While a finished result waits under out_stall the whole chain
// holds, and in_stall is raised in that same cycle. round_count (reset 20, capped at 20,
// odd counts rounded up) is written through the cfg channel, which is always ready; write
// it only while no block is in flight.
module salsa20_core_block (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  s20c_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output s20c_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [s20c_pkg::RC_W-1:0] cfg_data
);
  import s20c_pkg::*;

  logic [RC_W-1:0]    round_count_r;
  logic [RC_W-1:0]    rc_clamped;
  logic [RC_W:0]      rc_plus;
  logic               adv;
  stage_t             chain [NUM_CELLS+1];
  logic [NUM_CELLS:1] vld_vec;
  logic               out_valid_r;
  word_arr_t          res_r;
  word_arr_t          res_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= RC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      round_count_r <= cfg_data;
    end
  end

  assign rc_clamped = ({1'b0, round_count_r} > RC_MAX) ? RC_MAX[RC_W-1:0] : round_count_r;
  assign rc_plus    = {1'b0, rc_clamped} + (RC_W+1)'(1);

  // Advance the whole chain unless a finished result is held by the consumer.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign chain[0] = '{valid:   in_valid,
                      doubles: DR_W'(rc_plus >> 1),
                      orig:    word_arr_t'(in_data),
                      work:    word_arr_t'(in_data)};

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    s20c_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .cell_step  (3'(g % STEPS_PER_DR)),
      .cell_round (DR_W'(g / STEPS_PER_DR)),
      .stage_in   (chain[g]),
      .stage_out  (chain[g+1])
    );
  end

  for (genvar v = 1; v <= NUM_CELLS; v++) begin : g_vld
    assign vld_vec[v] = chain[v].valid;
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      res_nxt[i] = chain[NUM_CELLS].work[i] + chain[NUM_CELLS].orig[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_t'(res_r);

`ifndef SYNTHESIS
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && chain[NUM_CELLS].valid) |=> out_valid_r)
    else $error("finished block not moved into output register");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_vec[NUM_CELLS:1]))
    else $error("chain moved while result side stalled");

  a_doubles_range: assert property (@(posedge clk) disable iff (!rst_n)
    chain[NUM_CELLS].valid |-> (chain[NUM_CELLS].doubles <= DR_W'(MAX_DOUBLES)))
    else $error("double round count out of range at chain end");

  a_stall_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("held result dropped");
`endif

endmodule
